// ----- hw/rtl/alss_pkg.sv -----
// Package for the addressable LED strip sender: sizes, field layout,
// command and register codes. No dependencies.
package alss_pkg;

   localparam int LED_COUNT = 64;
   localparam int LED_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
   localparam logic [10:0] LED_COUNT_L = 11'(LED_COUNT);
   localparam logic [LED_W-1:0] LED_LAST = LED_W'(LED_COUNT - 1);

   localparam int COLOR_W = 24;
   localparam int BIT_W = 5;
   localparam logic [BIT_W-1:0] BIT_MSB = BIT_W'(COLOR_W - 1);

   localparam int TOP_W = 16;
   localparam int RP_W = 8;
   localparam int INDEX_W = 10;
   localparam int CHAN_W = 8;

   // request tdata layout, lowest bit first
   localparam int REQ_DATA_W = 40;
   localparam int IDX_LO = 0;
   localparam int RED_LO = IDX_LO + INDEX_W;
   localparam int GRN_LO = RED_LO + CHAN_W;
   localparam int BLU_LO = GRN_LO + CHAN_W;

   // request kinds carried in tuser
   localparam int FUNC_W = 2;
   localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_SHOW = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd2;

   // configuration register indexes
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PERIOD_TOP = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESET_PERIODS = 1'd1;
   localparam int CSR_DATA_W = 16;

   localparam logic [TOP_W-1:0] PERIOD_TOP_RST = 16'd104;
   localparam logic [RP_W-1:0] RESET_PERIODS_RST = 8'd100;

   // x/3 == (x * DIV3_RECIP) >> DIV3_SHIFT, exact for x < 2**19
   localparam logic [17:0] DIV3_RECIP = 18'd174763;
   localparam int DIV3_SHIFT = 19;

endpackage

// ----- hw/rtl/addressable_led_strip_sender.sv -----
// Addressable LED strip sender top level: pixel store, frame sequencer and
// duty output stage. Depends on alss_pkg and alss_duty.
//
// Keeps one GRB colour word per LED in a single-port synchronous memory
// (64 x 24) with a written flag per LED held in flops and cleared at reset.
// Request beats: kind FUNC_WRITE stores a pixel (indexes at or beyond the
// LED count are dropped), FUNC_SHOW arms a frame when idle, FUNC_TICK marks
// the start of a bit period and always yields one response beat carrying
// the PWM compare value for that period. A frame is all LEDs, 24 bits each,
// green first, MSB first, then reset_periods zero-duty latch periods; tlast
// marks the final latch period. Unwritten LEDs send zero duty. One request
// beat is taken per cycle; a tick's response passes through the memory read
// register and then the duty calculation into the output register. Stalls on
// the response side hold the pipeline, and request tready falls only when the
// stage behind the memory is full and blocked. The configuration port is
// always ready; users write it with the block idle (the block does not check).
module addressable_led_strip_sender (
   input  logic                                  clock,
   input  logic                                  reset,
   // request stream
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [alss_pkg::REQ_DATA_W-1:0]       req_tdata,  // led_index, red, green, blue, zero pad
   input  logic [alss_pkg::FUNC_W-1:0]           req_tuser,  // func
   // response stream
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [alss_pkg::TOP_W-1:0]            rsp_tdata,  // duty
   output logic                                  rsp_tlast,  // frame_last
   // configuration writes
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [alss_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [alss_pkg::CSR_DATA_W-1:0]       csr_data
);

   // configuration
   logic [alss_pkg::TOP_W-1:0] period_top_ff, period_top_in;
   logic [alss_pkg::RP_W-1:0]  reset_periods_ff, reset_periods_in;

   // pixel store
   logic [alss_pkg::COLOR_W-1:0] pixel_mem [alss_pkg::LED_COUNT];
   logic [alss_pkg::COLOR_W-1:0] pixel_q_ff;
   logic [alss_pkg::LED_COUNT-1:0] written_ff, written_in;

   // frame sequencer
   logic                         sending_ff, sending_in;
   logic                         latch_ff, latch_in;   // in latch (reset) periods
   logic [alss_pkg::LED_W-1:0]   led_ff, led_in;
   logic [alss_pkg::BIT_W-1:0]   bit_ff, bit_in;       // counts 23 down to 0
   logic [alss_pkg::RP_W-1:0]    latch_cnt_ff, latch_cnt_in;

   // stage behind the memory read
   logic                         s1_valid_ff, s1_valid_in;
   logic                         s1_data_ff;           // data period of a frame
   logic                         s1_written_ff;
   logic                         s1_last_ff;
   logic [alss_pkg::BIT_W-1:0]   s1_bit_ff;

   // output register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [alss_pkg::TOP_W-1:0]   rsp_duty_ff;
   logic                         rsp_last_ff;

   // request fields
   logic [alss_pkg::INDEX_W-1:0] idx;
   logic [alss_pkg::CHAN_W-1:0]  red, green, blue;
   logic                         req_fire, wr_fire, show_fire, tick_fire;
   logic                         idx_ok;
   logic                         s1_move;
   logic                         tick_last;
   logic [alss_pkg::RP_W:0]      rp_eff, latch_next;
   logic                         s1_one;
   logic [alss_pkg::TOP_W-1:0]   code;

   assign idx   = req_tdata[alss_pkg::IDX_LO +: alss_pkg::INDEX_W];
   assign red   = req_tdata[alss_pkg::RED_LO +: alss_pkg::CHAN_W];
   assign green = req_tdata[alss_pkg::GRN_LO +: alss_pkg::CHAN_W];
   assign blue  = req_tdata[alss_pkg::BLU_LO +: alss_pkg::CHAN_W];

   // handshakes
   assign s1_move   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || s1_move;
   assign req_fire  = req_tvalid && req_tready;
   assign wr_fire   = req_fire && (req_tuser == alss_pkg::FUNC_WRITE);
   assign show_fire = req_fire && (req_tuser == alss_pkg::FUNC_SHOW);
   assign tick_fire = req_fire && (req_tuser == alss_pkg::FUNC_TICK);
   assign idx_ok    = {1'b0, idx} < alss_pkg::LED_COUNT_L;
   assign csr_ready = 1'b1;

   // config registers
   always_comb begin
      period_top_in = period_top_ff;
      reset_periods_in = reset_periods_ff;
      if (csr_valid) begin
         case (csr_index)
            alss_pkg::CSR_PERIOD_TOP: period_top_in = csr_data;
            alss_pkg::CSR_RESET_PERIODS: reset_periods_in = csr_data[alss_pkg::RP_W-1:0];
            default: ;
         endcase
      end
   end

   // a latch length of zero counts as one
   assign rp_eff = (reset_periods_ff == '0) ? 9'd1 : {1'b0, reset_periods_ff};
   assign latch_next = {1'b0, latch_cnt_ff} + 9'd1;
   assign tick_last = sending_ff && latch_ff && (latch_next >= rp_eff);

   // frame sequencer
   always_comb begin
      sending_in = sending_ff;
      latch_in = latch_ff;
      led_in = led_ff;
      bit_in = bit_ff;
      latch_cnt_in = latch_cnt_ff;
      if (show_fire && !sending_ff) begin
         sending_in = 1'b1;
         latch_in = 1'b0;
         led_in = '0;
         bit_in = alss_pkg::BIT_MSB;
         latch_cnt_in = '0;
      end else if (tick_fire && sending_ff) begin
         if (!latch_ff) begin
            if (bit_ff == '0) begin
               bit_in = alss_pkg::BIT_MSB;
               if (led_ff == alss_pkg::LED_LAST) begin
                  latch_in = 1'b1;
                  latch_cnt_in = '0;
               end else begin
                  led_in = led_ff + 1'b1;
               end
            end else begin
               bit_in = bit_ff - 1'b1;
            end
         end else if (tick_last) begin
            sending_in = 1'b0;
            latch_in = 1'b0;
         end else begin
            latch_cnt_in = latch_next[alss_pkg::RP_W-1:0];
         end
      end
   end

   // written flags
   always_comb begin
      written_in = written_ff;
      if (wr_fire && idx_ok) begin
         written_in[idx[alss_pkg::LED_W-1:0]] = 1'b1;
      end
   end

   // pixel memory: write on a pixel beat, read on every tick
   always_ff @(posedge clock) begin
      if (wr_fire && idx_ok) begin
         pixel_mem[idx[alss_pkg::LED_W-1:0]] <= {green, red, blue};
      end
      if (tick_fire) begin
         pixel_q_ff <= pixel_mem[led_ff];
      end
   end

   assign s1_valid_in = tick_fire || (s1_valid_ff && !s1_move);

   // tick payload alongside the memory read
   always_ff @(posedge clock) begin
      if (tick_fire) begin
         s1_data_ff <= sending_ff && !latch_ff;
         s1_written_ff <= written_ff[led_ff];
         s1_last_ff <= tick_last;
         s1_bit_ff <= bit_ff;
      end
   end

   // duty for the stored bit
   assign s1_one = pixel_q_ff[s1_bit_ff];

   alss_duty u_duty (
      .period_top (period_top_ff),
      .one_bit    (s1_one),
      .code       (code)
   );

   assign rsp_valid_in = (s1_valid_ff && s1_move) || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s1_move) begin
         rsp_duty_ff <= (s1_data_ff && s1_written_ff) ? code : '0;
         rsp_last_ff <= s1_last_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         period_top_ff <= alss_pkg::PERIOD_TOP_RST;
         reset_periods_ff <= alss_pkg::RESET_PERIODS_RST;
         written_ff <= '0;
         sending_ff <= 1'b0;
         latch_ff <= 1'b0;
         led_ff <= '0;
         bit_ff <= alss_pkg::BIT_MSB;
         latch_cnt_ff <= '0;
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         period_top_ff <= period_top_in;
         reset_periods_ff <= reset_periods_in;
         written_ff <= written_in;
         sending_ff <= sending_in;
         latch_ff <= latch_in;
         led_ff <= led_in;
         bit_ff <= bit_in;
         latch_cnt_ff <= latch_cnt_in;
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_duty_ff;
   assign rsp_tlast = rsp_last_ff;

endmodule

// ----- hw/rtl/alss_duty.sv -----
// Duty code for one bit period: one third or two thirds of the period,
// clamped to [1, top]. Depends on alss_pkg.
module alss_duty (
   input  logic [alss_pkg::TOP_W-1:0] period_top,
   input  logic                       one_bit,
   output logic [alss_pkg::TOP_W-1:0] code
);

   logic [16:0] period_len;
   logic [17:0] numer;
   logic [35:0] prod;
   logic [16:0] quot;

   assign period_len = {1'b0, period_top} + 17'd1;
   assign numer = one_bit ? {period_len, 1'b0} : {1'b0, period_len};
   assign prod = numer * alss_pkg::DIV3_RECIP;
   assign quot = prod[35:alss_pkg::DIV3_SHIFT];

   always_comb begin
      if (quot == 17'd0) begin
         code = 16'd1;
      end else if (quot > {1'b0, period_top}) begin
         code = period_top;
      end else begin
         code = quot[15:0];
      end
   end

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for addressable_led_strip_sender: pixel store, frame
// sequencing, duty codes and latch periods. Depends on alss_pkg and the RTL.
// A behavioural copy of the strip predicts every period beat; a checker compares.
`timescale 1ns / 1ps

module testbench;
   import alss_pkg::*;

   // func code the block leaves unused; such beats are dropped without a response
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int DATA_PERIODS = LED_COUNT * COLOR_W;
   // quiet cycles allowed: well above the long receiver hold and random stalls
   localparam int WATCHDOG_LIMIT = 3000;
   // two-stage pipeline behind the request port, plus margin
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES = 200;

   typedef struct packed {
      logic [TOP_W-1:0] duty;
      logic             frame_last;
   } period_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;   // led_index, red, green, blue, zero pad
   logic [FUNC_W-1:0]       req_tuser = FUNC_TICK;   // func
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [TOP_W-1:0]        rsp_tdata;   // duty
   logic                    rsp_tlast;   // frame_last
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_INDEX_W-1:0]  csr_index = CSR_PERIOD_TOP;
   logic [CSR_DATA_W-1:0]   csr_data = '0;

   addressable_led_strip_sender uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Strip predictor: own copy of the pixel store, marks, frame position and
   // registers, advanced once per accepted request beat.
   // ---------------------------------------------------------------------
   logic [COLOR_W-1:0] colour_store [LED_COUNT];
   bit                 lit_mask [LED_COUNT];
   bit                 frame_active;
   int unsigned        frame_pos;
   logic [TOP_W-1:0]   cfg_top;
   logic [RP_W-1:0]    cfg_latch;
   period_type         pending_periods [$];

   int failures = 0;
   int beats_sent = 0;
   int periods_seen = 0;
   int frames_seen = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   bit hold_request = 1'b0;

   // compare value for one data bit at the current timer top
   function automatic logic [TOP_W-1:0] compare_value(input bit one);
      int unsigned span;
      int unsigned code;
      span = cfg_top + 1;
      code = one ? (2 * span) / 3 : span / 3;
      if (code == 0)
         code = 1;
      else if (code > cfg_top)
         code = cfg_top;
      return code[TOP_W-1:0];
   endfunction

   function automatic void clear_strip();
      for (int i = 0; i < LED_COUNT; i++) begin
         colour_store[i] = '0;
         lit_mask[i] = 1'b0;
      end
      frame_active = 1'b0;
      frame_pos = 0;
      cfg_top = PERIOD_TOP_RST;
      cfg_latch = RESET_PERIODS_RST;
   endfunction

   function automatic void advance_strip(input logic [FUNC_W-1:0] func,
                                         input logic [REQ_DATA_W-1:0] data);
      logic [INDEX_W-1:0] idx;
      period_type         beat;
      int unsigned        frame_len;
      int unsigned        led;
      int unsigned        bitpos;
      idx = data[IDX_LO +: INDEX_W];
      case (func)
         FUNC_WRITE: begin
            // indexes past the strip are dropped
            if (idx < LED_COUNT) begin
               colour_store[idx] = {data[GRN_LO +: CHAN_W], data[RED_LO +: CHAN_W],
                                    data[BLU_LO +: CHAN_W]};
               lit_mask[idx] = 1'b1;
            end
         end
         FUNC_SHOW: begin
            // show while busy is ignored
            if (!frame_active) begin
               frame_active = 1'b1;
               frame_pos = 0;
            end
         end
         FUNC_TICK: begin
            beat.duty = '0;
            beat.frame_last = 1'b0;
            if (frame_active) begin
               // zero latch length counts as one period
               frame_len = DATA_PERIODS + ((cfg_latch == 0) ? 1 : cfg_latch);
               if (frame_pos < DATA_PERIODS) begin
                  led = frame_pos / COLOR_W;
                  bitpos = COLOR_W - 1 - frame_pos % COLOR_W;
                  // unwritten LEDs stay at zero duty
                  if (lit_mask[led])
                     beat.duty = compare_value(colour_store[led][bitpos]);
               end
               // a latch shortened below the position ends the frame here
               if (frame_pos + 1 >= frame_len) begin
                  beat.frame_last = 1'b1;
                  frame_active = 1'b0;
                  frame_pos = 0;
                  frames_seen++;
               end else begin
                  frame_pos = frame_pos + 1;
               end
            end
            pending_periods.push_back(beat);
         end
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Beat builders
   // ---------------------------------------------------------------------
   function automatic logic [REQ_DATA_W-1:0] pixel_beat(input logic [INDEX_W-1:0] idx,
                                                        input logic [CHAN_W-1:0] red,
                                                        input logic [CHAN_W-1:0] green,
                                                        input logic [CHAN_W-1:0] blue);
      logic [REQ_DATA_W-1:0] data;
      data = '0;
      data[IDX_LO +: INDEX_W] = idx;
      data[RED_LO +: CHAN_W] = red;
      data[GRN_LO +: CHAN_W] = green;
      data[BLU_LO +: CHAN_W] = blue;
      return data;
   endfunction

   // random payload for beats whose data the block ignores
   function automatic logic [REQ_DATA_W-1:0] noise_beat();
      return pixel_beat(10'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
   endfunction

   // ---------------------------------------------------------------------
   // Request driver. Valid is left high after a beat; settle() lowers it,
   // so it never falls and rises within one step.
   // ---------------------------------------------------------------------
   task automatic send_item(input logic [FUNC_W-1:0] func,
                            input logic [REQ_DATA_W-1:0] data);
      while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= func;
      req_tdata <= data;
      do @(posedge clock); while (req_tready !== 1'b1);
      advance_strip(func, data);
      beats_sent++;
   endtask

   task automatic send_write(input int unsigned idx);
      send_item(FUNC_WRITE, pixel_beat(10'(idx), 8'($urandom), 8'($urandom), 8'($urandom)));
   endtask

   task automatic send_random_item();
      int unsigned pick;
      pick = $urandom_range(99, 0);
      if (pick < 80)
         send_item(FUNC_TICK, noise_beat());
      else if (pick < 94)
         send_write(($urandom_range(99, 0) < 85) ? $urandom_range(LED_COUNT - 1, 0)
                                                : $urandom_range(1023, LED_COUNT));
      else if (pick < 98)
         send_item(FUNC_SHOW, noise_beat());
      else
         send_item(FUNC_UNUSED, noise_beat());
   endtask

   // a run of ticks with some pixel writes mixed in
   task automatic run_ticks(input int count, input int write_pct);
      repeat (count) begin
         if ($urandom_range(99, 0) < write_pct)
            send_write($urandom_range(LED_COUNT + 7, 0));
         else
            send_item(FUNC_TICK, noise_beat());
      end
   endtask

   task automatic fill_strip(input int count);
      repeat (count) send_write($urandom_range(LED_COUNT - 1, 0));
   endtask

   // drop valid, wait for every expected period, then let the pipeline empty
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_periods.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         CSR_PERIOD_TOP: cfg_top = value;
         CSR_RESET_PERIODS: cfg_latch = value[RP_W-1:0];
         default: ;
      endcase
   endtask

   // both registers, block drained first; junk above the latch field
   task automatic configure(input logic [TOP_W-1:0] top, input logic [RP_W-1:0] latch);
      settle();
      write_csr(CSR_PERIOD_TOP, top);
      write_csr(CSR_RESET_PERIODS, {8'($urandom), latch});
      csr_valid <= 1'b0;
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      stall_pct = recv_pct;
   endtask

   // ---------------------------------------------------------------------
   // Response side: drives tready (random stalls, long hold on request)
   // and checks each period beat against the oldest expectation.
   // ---------------------------------------------------------------------
   initial begin
      int         hold_left;
      period_type want;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid === 1'b1 && rsp_tready) begin
            periods_seen++;
            if (pending_periods.size() == 0) begin
               $error("unexpected period beat: duty %0d, frame_last %0b", rsp_tdata, rsp_tlast);
               failures++;
            end else begin
               want = pending_periods.pop_front();
               if (rsp_tdata !== want.duty) begin
                  $error("duty: expected %0d, got %0d", want.duty, rsp_tdata);
                  failures++;
               end
               if (rsp_tlast !== want.frame_last) begin
                  $error("frame_last: expected %0b, got %0b", want.frame_last, rsp_tlast);
                  failures++;
               end
            end
         end
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !(stall_pct != 0 && $urandom_range(99, 0) < stall_pct);
         end
      end
   end

   // watchdog: too long without any beat on any channel ends the run
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("watchdog: %0d cycles without a beat", quiet);
      $display("testbench NOT OK");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Tests. One frame runs through most of them; register changes land
   // between stretches of it with the pipeline drained.
   // ---------------------------------------------------------------------

   // ticks with no frame armed give zero duty; unused func gives nothing
   task automatic test_idle_ticks();
      set_idling(0, 0);
      send_item(FUNC_TICK, '0);
      send_item(FUNC_UNUSED, noise_beat());
      send_item(FUNC_TICK, {{(REQ_DATA_W - 34){1'b0}}, {34{1'b1}}});
      send_item(FUNC_UNUSED, noise_beat());
      send_item(FUNC_TICK, noise_beat());
      settle();
   endtask

   // colour and index extremes; writes past the strip must not land
   task automatic test_pixel_store();
      send_item(FUNC_WRITE, pixel_beat(10'd0, 8'hFF, 8'hFF, 8'hFF));
      send_item(FUNC_WRITE, pixel_beat(10'd1, 8'h00, 8'h00, 8'h00));
      send_item(FUNC_WRITE, pixel_beat(10'd2, 8'h01, 8'h80, 8'hA5));
      send_item(FUNC_WRITE, pixel_beat(10'(LED_COUNT - 1), 8'hC3, 8'h5A, 8'h0F));
      send_item(FUNC_WRITE, pixel_beat(10'(LED_COUNT), 8'hFF, 8'hFF, 8'hFF));
      send_item(FUNC_WRITE, pixel_beat(10'd1023, 8'hFF, 8'hFF, 8'hFF));
      send_item(FUNC_WRITE, pixel_beat(10'd960, 8'hAA, 8'h55, 8'hAA));
      settle();
   endtask

   // frame start at reset register values: mostly unwritten LEDs, a second
   // show while busy, and writes landing mid-frame (sent and unsent LEDs)
   task automatic test_default_frame();
      send_item(FUNC_SHOW, noise_beat());
      send_item(FUNC_SHOW, noise_beat());
      repeat (30) send_item(FUNC_TICK, noise_beat());
      send_item(FUNC_WRITE, pixel_beat(10'd1, 8'hFF, 8'hFF, 8'hFF));
      send_item(FUNC_WRITE, pixel_beat(10'd0, 8'h00, 8'h00, 8'h00));
      send_item(FUNC_WRITE, pixel_beat(10'd10, 8'h0F, 8'hF0, 8'h3C));
      run_ticks(250, 0);
      settle();
   endtask

   // receiver holds off while ticks keep coming, so the request side stalls
   task automatic test_backpressure();
      set_idling(0, 0);
      send_item(FUNC_SHOW, noise_beat());
      hold_request = 1'b1;
      repeat (60) send_item(FUNC_TICK, noise_beat());
      run_ticks(40, 10);
      settle();
   endtask

   // timer top at its extremes, each stretch under a different idle pattern
   task automatic test_register_extremes();
      set_idling(83, 0);
      configure(16'd0, 8'd0);
      fill_strip(8);
      run_ticks(120, 10);

      set_idling(0, 83);
      configure(16'hFFFF, 8'd255);
      fill_strip(8);
      run_ticks(120, 10);

      set_idling(10, 10);
      configure(16'd2, 8'd1);
      fill_strip(8);
      run_ticks(120, 10);
      settle();
   endtask

   // mixed traffic with register changes between idle patterns
   task automatic test_random_traffic();
      int send_pct [4] = '{0, 83, 0, 10};
      int recv_pct [4] = '{0, 0, 83, 10};
      for (int phase = 0; phase < 4; phase++) begin
         set_idling(send_pct[phase], recv_pct[phase]);
         configure(($urandom_range(1, 0) == 0) ? 16'($urandom_range(8, 0)) : 16'($urandom),
                   8'($urandom_range(255, 0)));
         send_item(FUNC_SHOW, noise_beat());
         repeat (100) send_random_item();
      end
      settle();
   endtask

   // latch cut to zero below the current position: the next tick closes the
   // frame; a later show arms a fresh one from the first LED
   task automatic test_latch_shortened();
      set_idling(0, 0);
      configure(16'd30, 8'd200);
      while (frame_active && frame_pos < DATA_PERIODS + 10)
         send_item(FUNC_TICK, noise_beat());
      configure(16'd30, 8'd0);
      send_item(FUNC_TICK, noise_beat());
      send_item(FUNC_TICK, noise_beat());
      send_item(FUNC_SHOW, noise_beat());
      repeat (3) send_item(FUNC_TICK, noise_beat());
      settle();
   endtask

   initial begin
      clear_strip();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_idle_ticks();
      test_pixel_store();
      test_default_frame();
      test_backpressure();
      test_register_extremes();
      test_random_traffic();
      test_latch_shortened();

      set_idling(0, 0);
      settle();
      $display("%0d request beats, %0d period beats checked, %0d frames completed",
               beats_sent, periods_seen, frames_seen);
      $display("idle ticks, pixel limits, show while busy, hold-off, timer extremes, "
               + "random mix, latch cut and re-arm");
      if (failures == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/alss_pkg.sv
hw/rtl/alss_duty.sv
hw/rtl/addressable_led_strip_sender.sv
tb/sv/testbench.sv
